>>> hdl/dab_superframe_au_splitter_defines.svh
// ----------------------------------------------------------------------------
// DAB+ superframe AU splitter assertion macros
// Shared property macros, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DAB_SUPERFRAME_AU_SPLITTER_DEFINES_SVH
`define DAB_SUPERFRAME_AU_SPLITTER_DEFINES_SVH

// Same-cycle implication.
`define DSAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dsau_pkg.sv
// ----------------------------------------------------------------------------
// DAB+ superframe AU splitter package
// Shared types, tables and constants of the AU splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsau_pkg;

  localparam int OUT_BUF_BYTES       = 4096;
  localparam int AUDIO_BYTES_PER_COL = 110;
  localparam int MAX_AUS             = 6;

  // AU count and ADTS sampling-frequency index, selected by the rate and SBR flags.
  localparam logic [2:0] AU_COUNT_TAB [4] = '{3'd4, 3'd2, 3'd6, 3'd3};
  localparam logic [3:0] SFI_TAB [4]      = '{4'h5, 4'h8, 4'h3, 4'h6};

  localparam logic [7:0] ADTS_BYTE0     = 8'hFF;
  localparam logic [7:0] ADTS_BYTE1     = 8'hF1;
  localparam logic [7:0] ADTS_PROFILE   = 8'h40;
  localparam logic [4:0] ADTS_FULL_HIGH = 5'h1F;
  localparam logic [7:0] ADTS_BYTE6     = 8'hFC;

  typedef logic [MAX_AUS-1:0][11:0] start_arr_t;

  typedef struct packed {
    logic [2:0] au_count;
    logic       all_set;
    logic [1:0] sel;
    logic       sbr;
    logic       mode;
    logic       ps;
    logic [2:0] surround;
  } hdr_info_t;

  typedef struct packed {
    logic [11:0] unit_start;
    logic [13:0] unit_size;
    logic        in_range;
    logic        emit_ok;
    logic [55:0] adts_header;
  } au_result_t;

endpackage

`default_nettype wire

>>> hdl/dab_superframe_au_splitter.sv
// ----------------------------------------------------------------------------
// DAB+ superframe AU splitter
// Splits one DAB+ superframe header into per-AU results with ADTS headers.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one superframe header per transfer: s_tdata holds
//   the format byte and header bytes 3 to 10. The master stream gives one
//   transfer per access unit (2, 3, 4 or 6 per superframe), in order, with
//   m_tlast on the final one. cfg_we/cfg_wdata write rs_columns, which sets
//   the audio area to 110 bytes per column; write it only while idle.
// Flow:
//   A header moves into the header register, and its first AU result then
//   into the output register. Results leave one per cycle while m_tready is
//   high; a superframe has 2 to 6 AUs, which the header register feeds one
//   at a time to the single AU calculator. The next header is taken in the
//   cycle its predecessor's last AU moves into the output register.
// Reset and stall:
//   rst clears both streams and sets rs_columns to 8. When the receiver holds
//   m_tready low, the output register keeps its result and the header
//   register waits; no result is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dab_superframe_au_splitter_defines.svh"

module dab_superframe_au_splitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: format_byte, hdr_byte3 .. hdr_byte10 (8 bits each).
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Fields from bit 0: au_number[3], unit_start[12], unit_size[14],
  // in_range[1], emit_ok[1], adts_header[56], one zero pad bit.
  output logic [87:0]      m_tdata,
  output logic             m_tlast
);

  logic [12:0]          area_bytes;
  dsau_pkg::start_arr_t in_starts;
  dsau_pkg::hdr_info_t  in_info;
  dsau_pkg::start_arr_t hdr_starts;
  dsau_pkg::hdr_info_t  hdr_info;
  logic                 hdr_valid;
  logic [2:0]           au_idx;
  logic                 last;
  logic                 load;
  logic [12:0]          next_pos;
  dsau_pkg::au_result_t calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_bytes <= 13'(dsau_pkg::AUDIO_BYTES_PER_COL * 8);
    end else if (cfg_we) begin
      area_bytes <= 13'(dsau_pkg::AUDIO_BYTES_PER_COL) * {7'd0, cfg_wdata};
    end
  end

  dsau_hdr_unpack u_unpack (
    .hdr_bytes (s_tdata),
    .starts    (in_starts),
    .info      (in_info)
  );

  assign last     = (au_idx == (hdr_info.au_count - 3'd1));
  assign load     = hdr_valid && (!m_tvalid || m_tready);
  assign s_tready = !hdr_valid || (load && last);
  assign next_pos = last ? area_bytes : {1'b0, hdr_starts[1]};

  // The start list shifts down as AUs go out, so the current AU is always
  // at slot 0 and its successor at slot 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
      au_idx    <= '0;
    end else if (s_tvalid && s_tready) begin
      hdr_valid <= 1'b1;
      au_idx    <= '0;
    end else if (load) begin
      if (last) begin
        hdr_valid <= 1'b0;
      end else begin
        au_idx <= au_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hdr_starts <= in_starts;
      hdr_info   <= in_info;
    end else if (load) begin
      for (int i = 0; i < dsau_pkg::MAX_AUS - 1; i++) begin
        hdr_starts[i] <= hdr_starts[i+1];
      end
    end
  end

  dsau_au_calc u_calc (
    .cur_start  (hdr_starts[0]),
    .next_pos   (next_pos),
    .area_bytes (area_bytes),
    .info       (hdr_info),
    .result     (calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, calc.adts_header, calc.emit_ok, calc.in_range,
                  calc.unit_size, calc.unit_start, au_idx};
      m_tlast <= last;
    end
  end

  `DSAU_ASSERT_IMP(a_idx_in_count, hdr_valid, au_idx < hdr_info.au_count, "AU index past count")
  `DSAU_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, hdr_valid && au_idx == 3'd0, "no header")
  `DSAU_ASSERT_IMP(a_emit_in_range, m_tvalid && m_tdata[30], m_tdata[29], "emit without range")
  `DSAU_ASSERT_IMP(a_no_emit_hdr, m_tvalid && !m_tdata[30], m_tdata[86:31] == 56'd0, "stray ADTS")

endmodule

`default_nettype wire

>>> hdl/dsau_hdr_unpack.sv
// ----------------------------------------------------------------------------
// DAB+ superframe header unpacker
// Splits the superframe header bytes into AU starts and format fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsau_hdr_unpack (
  input  wire logic [71:0]         hdr_bytes,
  output dsau_pkg::start_arr_t     starts,
  output dsau_pkg::hdr_info_t      info
);

  logic [7:0]  fmt;
  logic [7:0]  b3, b4, b5, b6, b7, b8, b9, b10;
  logic [1:0]  sel;
  logic [2:0]  count;
  logic [11:0] start0;
  logic        all_set;

  assign fmt = hdr_bytes[7:0];
  assign b3  = hdr_bytes[15:8];
  assign b4  = hdr_bytes[23:16];
  assign b5  = hdr_bytes[31:24];
  assign b6  = hdr_bytes[39:32];
  assign b7  = hdr_bytes[47:40];
  assign b8  = hdr_bytes[55:48];
  assign b9  = hdr_bytes[63:56];
  assign b10 = hdr_bytes[71:64];

  assign sel   = fmt[6:5];
  assign count = dsau_pkg::AU_COUNT_TAB[sel];

  // The first AU starts right after the header, whose length follows the count.
  always_comb begin
    case (count)
      3'd2:    start0 = 12'd5;
      3'd3:    start0 = 12'd6;
      3'd4:    start0 = 12'd8;
      default: start0 = 12'd11;
    endcase
  end

  assign starts[0] = start0;
  assign starts[1] = {b3, b4[7:4]};
  assign starts[2] = {b4[3:0], b5};
  assign starts[3] = {b6, b7[7:4]};
  assign starts[4] = {b7[3:0], b8};
  assign starts[5] = {b9, b10[7:4]};

  always_comb begin
    all_set = 1'b1;
    for (int i = 1; i < dsau_pkg::MAX_AUS; i++) begin
      if ((3'(i) < count) && (starts[i] == 12'd0)) begin
        all_set = 1'b0;
      end
    end
  end

  assign info.au_count = count;
  assign info.all_set  = all_set;
  assign info.sel      = sel;
  assign info.sbr      = fmt[5];
  assign info.mode     = fmt[4];
  assign info.ps       = fmt[3];
  assign info.surround = fmt[2:0];

endmodule

`default_nettype wire

>>> hdl/dsau_au_calc.sv
// ----------------------------------------------------------------------------
// DAB+ access-unit calculator
// Size, range check, emit decision and ADTS header for one access unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsau_au_calc (
  input  wire logic [11:0]         cur_start,
  input  wire logic [12:0]         next_pos,
  input  wire logic [12:0]         area_bytes,
  input  wire dsau_pkg::hdr_info_t info,
  output dsau_pkg::au_result_t     result
);

  localparam logic signed [14:0] DLEN_LIMIT = 15'(dsau_pkg::OUT_BUF_BYTES - 7);

  logic signed [14:0] size;
  logic signed [14:0] end_pos;
  logic signed [14:0] dlen;
  logic signed [14:0] flen_full;
  logic [12:0]        flen;
  logic               rng;
  logic               emit;
  logic [2:0]         cc;
  logic [3:0]         sfi;

  always_comb begin
    if (info.all_set) begin
      size = $signed({2'b00, next_pos}) - $signed({3'b000, cur_start});
    end else begin
      size = '0;
    end
  end

  assign end_pos   = $signed({3'b000, cur_start}) + size;
  assign rng       = (size > 15'sd0) && (end_pos >= 15'sd2) &&
                     (end_pos <= $signed({2'b00, area_bytes}));
  assign dlen      = size - 15'sd2;
  assign emit      = rng && (dlen > 15'sd0) && (dlen < DLEN_LIMIT);
  // Frame length covers the data plus the seven header bytes.
  assign flen_full = dlen + 15'sd7;
  assign flen      = flen_full[12:0];

  always_comb begin
    if ((info.surround == 3'd0) && info.sbr && !info.mode && info.ps) begin
      cc = 3'd2;
    end else if (info.surround == 3'd1) begin
      cc = 3'd6;
    end else if (info.mode) begin
      cc = 3'd2;
    end else begin
      cc = 3'd1;
    end
  end

  assign sfi = dsau_pkg::SFI_TAB[info.sel];

  assign result.unit_start = cur_start;
  assign result.unit_size  = size[13:0];
  assign result.in_range   = rng;
  assign result.emit_ok    = emit;

  always_comb begin
    if (emit) begin
      result.adts_header = {dsau_pkg::ADTS_BYTE0,
                            dsau_pkg::ADTS_BYTE1,
                            dsau_pkg::ADTS_PROFILE | {2'b00, sfi, 2'b00} |
                              {7'b0000000, cc[2]},
                            {cc[1:0], 4'b0000, flen[12:11]},
                            flen[10:3],
                            {flen[2:0], dsau_pkg::ADTS_FULL_HIGH},
                            dsau_pkg::ADTS_BYTE6};
    end else begin
      result.adts_header = '0;
    end
  end

endmodule

`default_nettype wire
